// ----- design/ybi_pkg.sv -----
// shared types and constants for the yaml block indentation event parser
`timescale 1ns / 1ps
package ybi_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // token kinds
  localparam logic [1:0] TK_BARE     = 2'd0;
  localparam logic [1:0] TK_QUOTED   = 2'd1;
  localparam logic [1:0] TK_LINE_END = 2'd2;
  localparam logic [1:0] TK_FILE_END = 2'd3;

  // leading character classes
  localparam logic [3:0] LC_OTHER = 4'd0;
  localparam logic [3:0] LC_BANG  = 4'd7;
  localparam logic [3:0] LC_DASH  = 4'd8;

  // event codes
  localparam logic [3:0] EV_DIRECTIVES = 4'd7;
  localparam logic [3:0] EV_SEQ_ENTRY  = 4'd8;
  localparam logic [3:0] EV_BARE       = 4'd9;
  localparam logic [3:0] EV_KEY        = 4'd10;
  localparam logic [3:0] EV_CONTINUED  = 4'd11;
  localparam logic [3:0] EV_QUOTED     = 4'd12;
  localparam logic [3:0] EV_FILE_END   = 4'd13;
  localparam logic [3:0] EV_ERROR      = 4'd14;

  // nesting entry kinds
  localparam logic KIND_MAP = 1'b0;
  localparam logic KIND_SEQ = 1'b1;

  typedef struct packed {
    logic [7:0] ind;
    logic       kind;
    logic [5:0] seql;
    logic [5:0] mapl;
  } nest_entry_t;

endpackage

// ----- design/yaml_block_indent_event_parser_top.sv -----
// Block-indentation event parser for a YAML token stream.
//
// Input channel (in_*): one tokenizer token per beat, taken when in_valid is
// high and in_stall is low. Output channel (out_*): at most one event per
// token, held in an output register until taken (out_valid high, out_stall
// low). Tokens absorbed into a bare scalar and line ends give no event.
//
// The nesting stack lives in a 32-entry synchronous RAM with a registered
// read. Each token takes two steps: one to read the stack top, one to
// update and emit. A token that enters the pop loop (a dedent, or a key at or
// below the stack top) pops one entry per step, then checks the new top
// before it emits. A stalled output can hold the emitting step.
//
// A stalled output only holds the block when a new event is ready to load;
// the next token is still accepted while an event waits in the register.
// Reset clears the stack count, sets first-on-line and drops any scalar in
// progress; stack contents are left as they are.
`timescale 1ns / 1ps
module yaml_block_indent_event_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_token_kind,
  input  logic [3:0]  in_lead_char,
  input  logic        in_is_triple_dash,
  input  logic        in_second_is_space,
  input  logic [7:0]  in_indent,
  input  logic        in_colon_suffixed,
  input  logic [15:0] in_text_offset,
  input  logic [15:0] in_text_length,
  input  logic        in_ends_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_kind,
  output logic [5:0]  out_seq_depth,
  output logic [5:0]  out_map_depth,
  output logic signed [6:0] out_seq_delta,
  output logic signed [6:0] out_map_delta,
  output logic [7:0]  out_margin,
  output logic [15:0] out_event_offset,
  output logic [15:0] out_event_length
);
  import ybi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOP  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic        first_r, first_nxt;
  logic        absorb_r, absorb_nxt;
  logic [15:0] sstart_r, sstart_nxt;
  logic [7:0]  smargin_r, smargin_nxt;

  // latched token
  logic [1:0]  tk_r;
  logic [3:0]  lead_r;
  logic        triple_r, space2_r, colon_r, eol_r;
  logic [7:0]  ind_r;
  logic [15:0] off_r, len_r;

  // pending event for the pop loop
  logic [3:0]  pev_r, pev_nxt;
  logic        perr_r, perr_nxt;
  logic        pkey_r, pkey_nxt;
  logic signed [6:0] sd_r, sd_nxt, md_r, md_nxt;
  logic [5:0]  tseq_r, tseq_nxt, tmap_r, tmap_nxt;
  logic [15:0] peoff_r, peoff_nxt, pelen_r, pelen_nxt;

  // stack memory
  nest_entry_t mem [STACK_DEPTH];
  nest_entry_t rd_r;
  logic        wr_en;
  nest_entry_t wr_data;
  logic [ADDR_W-1:0] rd_addr;

  // output register
  logic        ov_r, ov_nxt;
  logic [3:0]  oev_r;
  logic [5:0]  osd_r, omd_r;
  logic signed [6:0] osdl_r, omdl_r;
  logic [7:0]  omar_r;
  logic [15:0] ooff_r, olen_r;

  logic        emit;
  logic [3:0]  e_ev;
  logic signed [6:0] e_sd, e_md;
  logic [5:0]  e_tseq, e_tmap;
  logic [7:0]  e_mar;
  logic [15:0] e_off, e_len;

  logic        out_free, accept, have_top;
  logic [3:0]  lead;
  logic        pop_go;

  assign out_free = !ov_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign have_top = (cnt_r != '0);
  assign lead     = (lead_r > LC_DASH) ? LC_OTHER : lead_r;
  assign cnt_dec  = cnt_nxt - CNT_W'(1);
  assign rd_addr  = cnt_dec[ADDR_W-1:0];

  // pop condition on the current stack top
  assign pop_go = have_top && ((rd_r.ind > ind_r) ||
                  (pkey_r && rd_r.kind == KIND_SEQ && rd_r.ind == ind_r));

  // main step logic
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    first_nxt   = first_r;
    absorb_nxt  = absorb_r;
    sstart_nxt  = sstart_r;
    smargin_nxt = smargin_r;
    pev_nxt     = pev_r;
    perr_nxt    = perr_r;
    pkey_nxt    = pkey_r;
    sd_nxt      = sd_r;
    md_nxt      = md_r;
    tseq_nxt    = tseq_r;
    tmap_nxt    = tmap_r;
    peoff_nxt   = peoff_r;
    pelen_nxt   = pelen_r;
    wr_en       = 1'b0;
    wr_data     = '{ind: ind_r, kind: KIND_SEQ, seql: '0, mapl: '0};
    emit        = 1'b0;
    e_ev        = EV_ERROR;
    e_sd        = '0;
    e_md        = '0;
    e_tseq      = have_top ? rd_r.seql : 6'd0;
    e_tmap      = have_top ? rd_r.mapl : 6'd0;
    e_mar       = ind_r;
    e_off       = off_r;
    e_len       = len_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_TOP;
      end
      S_TOP: begin
        if (absorb_r) begin
          if (!eol_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            emit       = 1'b1;
            e_ev       = EV_BARE;
            e_mar      = smargin_r;
            e_off      = sstart_r;
            e_len      = off_r - sstart_r + len_r;
            absorb_nxt = 1'b0;
            first_nxt  = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else if (tk_r == TK_LINE_END) begin
          first_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (tk_r == TK_BARE && !(lead >= 4'd1 && lead <= LC_BANG) &&
                     !(lead == LC_DASH && (triple_r || (first_r && space2_r))) &&
                     !(lead == LC_OTHER && (colon_r || first_r)) && !eol_r) begin
          // bare scalar that runs on past this token
          first_nxt   = 1'b0;
          absorb_nxt  = 1'b1;
          sstart_nxt  = off_r;
          smargin_nxt = ind_r;
          state_nxt   = S_IDLE;
        end else begin
          logic       err;
          logic       go_pop;
          logic [3:0] ev;
          err    = 1'b0;
          go_pop = 1'b0;
          ev     = EV_BARE;
          if (tk_r == TK_FILE_END) begin
            ev    = EV_FILE_END;
            e_off = '0;
            e_len = '0;
          end else if (tk_r == TK_QUOTED) begin
            ev = EV_QUOTED;
          end else if (lead >= 4'd1 && lead <= LC_BANG) begin
            ev    = lead - 4'd1;
            e_off = off_r + 16'd1;
            e_len = (len_r != '0) ? len_r - 16'd1 : 16'd0;
          end else if (lead == LC_DASH && triple_r) begin
            ev = EV_DIRECTIVES;
          end else if (lead == LC_DASH && first_r && space2_r) begin
            ev    = EV_SEQ_ENTRY;
            e_len = '0;
            if (!have_top || ind_r > rd_r.ind ||
                (ind_r == rd_r.ind && rd_r.kind == KIND_MAP)) begin
              if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                if (out_free) begin
                  wr_en = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
                wr_data = '{ind: ind_r, kind: KIND_SEQ, seql: e_tseq + 6'd1,
                            mapl: e_tmap};
                e_sd = 7'sd1;
              end else begin
                err = 1'b1;
              end
            end else if (ind_r < rd_r.ind) begin
              go_pop = 1'b1;
            end
          end else if (lead == LC_OTHER && colon_r) begin
            ev = EV_KEY;
            if (!first_r) err = 1'b1;
            if (!have_top || ind_r > rd_r.ind) begin
              if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                if (out_free) begin
                  wr_en = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
                wr_data = '{ind: ind_r, kind: KIND_MAP, seql: e_tseq,
                            mapl: e_tmap + 6'd1};
                e_md = 7'sd1;
              end else begin
                err = 1'b1;
              end
            end else begin
              go_pop = 1'b1;
            end
          end else if (lead == LC_OTHER && first_r) begin
            ev = EV_CONTINUED;
            if (!have_top || ind_r <= rd_r.ind) err = 1'b1;
          end
          if (go_pop) begin
            // hand off to the pop loop, event waits in pending registers
            first_nxt = 1'b0;
            pev_nxt   = ev;
            perr_nxt  = err;
            pkey_nxt  = (ev == EV_KEY);
            sd_nxt    = '0;
            md_nxt    = '0;
            tseq_nxt  = e_tseq;
            tmap_nxt  = e_tmap;
            peoff_nxt = e_off;
            pelen_nxt = e_len;
            state_nxt = S_POP;
          end else if (out_free) begin
            emit      = 1'b1;
            e_ev      = err ? EV_ERROR : ev;
            first_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_POP: begin
        e_tseq = tseq_r;
        e_tmap = tmap_r;
        e_sd   = sd_r;
        e_md   = md_r;
        e_off  = peoff_r;
        e_len  = pelen_r;
        if (pop_go) begin
          // one entry per cycle, next top is read meanwhile
          cnt_nxt = cnt_r - CNT_W'(1);
          if (rd_r.kind == KIND_SEQ) sd_nxt = sd_r - 7'sd1;
          else md_nxt = md_r - 7'sd1;
        end else if (out_free) begin
          emit = 1'b1;
          e_ev = (perr_r || (pkey_r && (!have_top || rd_r.ind != ind_r))) ?
                 EV_ERROR : pev_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack memory, read of the next top every cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[ADDR_W-1:0]] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      first_r  <= 1'b1;
      absorb_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      absorb_r <= absorb_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    sstart_r  <= sstart_nxt;
    smargin_r <= smargin_nxt;
    pev_r     <= pev_nxt;
    perr_r    <= perr_nxt;
    pkey_r    <= pkey_nxt;
    sd_r      <= sd_nxt;
    md_r      <= md_nxt;
    tseq_r    <= tseq_nxt;
    tmap_r    <= tmap_nxt;
    peoff_r   <= peoff_nxt;
    pelen_r   <= pelen_nxt;
    if (accept) begin
      tk_r     <= in_token_kind;
      lead_r   <= in_lead_char;
      triple_r <= in_is_triple_dash;
      space2_r <= in_second_is_space;
      ind_r    <= in_indent;
      colon_r  <= in_colon_suffixed;
      off_r    <= in_text_offset;
      len_r    <= in_text_length;
      eol_r    <= in_ends_line;
    end
  end

  // output register
  always_comb begin
    ov_nxt = ov_r && out_stall;
    if (emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oev_r  <= e_ev;
      osd_r  <= e_tseq + e_sd[5:0];
      omd_r  <= e_tmap + e_md[5:0];
      osdl_r <= e_sd;
      omdl_r <= e_md;
      omar_r <= e_mar;
      ooff_r <= e_off;
      olen_r <= e_len;
    end
  end

  assign out_valid        = ov_r;
  assign out_event_kind   = oev_r;
  assign out_seq_depth    = osd_r;
  assign out_map_depth    = omd_r;
  assign out_seq_delta    = osdl_r;
  assign out_map_delta    = omdl_r;
  assign out_margin       = omar_r;
  assign out_event_offset = ooff_r;
  assign out_event_length = olen_r;

endmodule

// ----- design/ybi_checker.sv -----
// port-level checks for the yaml block indentation event parser
`timescale 1ns / 1ps
module ybi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_event_kind,
  input logic signed [6:0] out_seq_delta,
  input logic signed [6:0] out_map_delta,
  input logic [15:0] out_event_offset,
  input logic [15:0] out_event_length
);
  import ybi_pkg::*;

  // a waiting event is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("event dropped under stall");

  // no event straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event right after reset");

  // an accepted token blocks the input for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second token taken while busy");

  // an event never both pushes a sequence and a mapping
  a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_seq_delta == 7'sd1 && out_map_delta == 7'sd1))
    else $error("double push");

  // file end carries an empty text span
  a_file_end_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_FILE_END |->
      out_event_offset == 16'd0 && out_event_length == 16'd0)
    else $error("file end with text");

endmodule

bind yaml_block_indent_event_parser_top ybi_checker u_ybi_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_event_kind(out_event_kind), .out_seq_delta(out_seq_delta),
  .out_map_delta(out_map_delta), .out_event_offset(out_event_offset),
  .out_event_length(out_event_length)
);

// ----- sim/tb.sv -----
// testbench for the yaml block indentation event parser
`timescale 1ns / 1ps
module tb;
  import ybi_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  seq_depth;
    logic [5:0]  map_depth;
    logic [6:0]  seq_delta;
    logic [6:0]  map_delta;
    logic [7:0]  margin;
    logic [15:0] offset;
    logic [15:0] length;
  } event_t;

  typedef struct packed {
    logic [1:0]  tk;
    logic [3:0]  lead;
    logic        triple;
    logic        space2;
    logic [7:0]  indent;
    logic        colon;
    logic [15:0] offset;
    logic [15:0] length;
    logic        eol;
  } token_t;

  // event predictor with its own copy of the nesting state
  class event_scoreboard;
    nest_entry_t nest [STACK_DEPTH];
    int          depth;
    bit          line_start;
    bit          in_scalar;
    logic [15:0] scalar_off;
    logic [7:0]  scalar_ind;
    event_t      pending [$];
    int          mismatches;

    function void clear();
      depth = 0;
      line_start = 1;
      in_scalar = 0;
      scalar_off = '0;
      scalar_ind = '0;
    endfunction

    function bit push(logic k, logic [7:0] ind, int sl, int ml);
      if (depth >= STACK_DEPTH) return 0;
      nest[depth] = '{ind: ind, kind: k, seql: sl[5:0], mapl: ml[5:0]};
      depth++;
      return 1;
    endfunction

    // pop entries indented deeper, a key also pops a sequence at equal indent
    function void unwind(logic [7:0] ind, bit seq_eq, inout int sd, inout int md);
      while (depth > 0) begin
        if (!(nest[depth-1].ind > ind ||
              (seq_eq && nest[depth-1].kind == KIND_SEQ && nest[depth-1].ind == ind)))
          break;
        if (nest[depth-1].kind == KIND_SEQ) sd--; else md--;
        depth--;
      end
    endfunction

    function void note_token(token_t t);
      int tseq, tmap, sd, md, top_ind;
      logic [3:0] ev, lead;
      bit err;
      logic [15:0] eoff, elen;
      event_t e;
      tseq = 0; tmap = 0; sd = 0; md = 0; err = 0;
      eoff = t.offset; elen = t.length; lead = t.lead;
      if (depth > 0) begin
        tseq = nest[depth-1].seql;
        tmap = nest[depth-1].mapl;
      end
      if (in_scalar) begin
        if (!t.eol) return;
        in_scalar = 0;
        line_start = 0;
        e = '{EV_BARE, tseq[5:0], tmap[5:0], 7'd0, 7'd0, scalar_ind, scalar_off,
              16'(t.offset - scalar_off + t.length)};
        pending.push_back(e);
        return;
      end
      if (t.tk == TK_LINE_END) begin
        line_start = 1;
        return;
      end
      if (lead > LC_DASH) lead = LC_OTHER;
      if (t.tk == TK_FILE_END) begin
        ev = EV_FILE_END; eoff = 0; elen = 0;
      end else if (t.tk == TK_QUOTED) begin
        ev = EV_QUOTED;
      end else if (lead >= 4'd1 && lead <= LC_BANG) begin
        ev = lead - 4'd1;
        eoff = t.offset + 16'd1;
        elen = (t.length != 0) ? t.length - 16'd1 : 16'd0;
      end else if (lead == LC_DASH && t.triple) begin
        ev = EV_DIRECTIVES;
      end else if (lead == LC_DASH && line_start && t.space2) begin
        top_ind = (depth > 0) ? int'(nest[depth-1].ind) : -1;
        ev = EV_SEQ_ENTRY;
        elen = 0;
        if (int'(t.indent) > top_ind ||
            (int'(t.indent) == top_ind && nest[depth-1].kind == KIND_MAP)) begin
          if (push(KIND_SEQ, t.indent, tseq + 1, tmap)) sd = 1; else err = 1;
        end else if (int'(t.indent) < top_ind) begin
          unwind(t.indent, 0, sd, md);
        end
      end else if (lead == LC_OTHER && t.colon) begin
        ev = EV_KEY;
        if (!line_start) err = 1;
        if (depth == 0 || t.indent > nest[depth-1].ind) begin
          if (push(KIND_MAP, t.indent, tseq, tmap + 1)) md = 1; else err = 1;
        end else begin
          unwind(t.indent, 1, sd, md);
          if (depth == 0 || nest[depth-1].ind != t.indent) err = 1;
        end
      end else if (lead == LC_OTHER && line_start) begin
        ev = EV_CONTINUED;
        if (depth == 0 || t.indent <= nest[depth-1].ind) err = 1;
      end else begin
        line_start = 0;
        if (!t.eol) begin
          in_scalar = 1;
          scalar_off = t.offset;
          scalar_ind = t.indent;
          return;
        end
        ev = EV_BARE;
      end
      line_start = 0;
      if (err) ev = EV_ERROR;
      e.kind = ev;
      e.seq_depth = 6'(tseq + sd);
      e.map_depth = 6'(tmap + md);
      e.seq_delta = 7'(sd);
      e.map_delta = 7'(md);
      e.margin = t.indent;
      e.offset = eoff;
      e.length = elen;
      pending.push_back(e);
    endfunction

    function void check_event(event_t got);
      event_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("event mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  token_t      tok;
  event_t      got;
  event_scoreboard sb;
  int          send_idle, recv_stall;
  bit          hold_off;
  int          cycles;

  yaml_block_indent_event_parser_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_token_kind(tok.tk), .in_lead_char(tok.lead),
    .in_is_triple_dash(tok.triple), .in_second_is_space(tok.space2),
    .in_indent(tok.indent), .in_colon_suffixed(tok.colon),
    .in_text_offset(tok.offset), .in_text_length(tok.length),
    .in_ends_line(tok.eol),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_kind(got.kind), .out_seq_depth(got.seq_depth),
    .out_map_depth(got.map_depth), .out_seq_delta(got.seq_delta),
    .out_map_delta(got.map_delta), .out_margin(got.margin),
    .out_event_offset(got.offset), .out_event_length(got.length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall);
  end

  // check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_event(got);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one token and wait until it is accepted; valid stays up for the
  // next call, which drops it during idle cycles
  task automatic send_token(token_t t);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tok <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_token(t);
  endtask

  function automatic token_t mk(int tk, int lead, int ind, int colon, int eol);
    token_t t;
    t.tk = tk[1:0]; t.lead = lead[3:0]; t.indent = ind[7:0];
    t.colon = colon[0]; t.eol = eol[0];
    t.triple = 1'b0; t.space2 = (lead[3:0] == LC_DASH);
    t.offset = 16'($urandom); t.length = 16'($urandom_range(40));
    return t;
  endfunction

  task automatic send_line_end();
    send_token(mk(TK_LINE_END, 0, 0, 0, 1));
  endtask

  // well-formed lines with random nesting, plus some noise
  task automatic random_tokens(int n);
    token_t t;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 15) t = mk(TK_LINE_END, $urandom, $urandom, $urandom, $urandom);
      else if (r < 40) t = mk(TK_BARE, LC_DASH, 4 * $urandom_range(8), 0, $urandom);
      else if (r < 65) t = mk(TK_BARE, LC_OTHER, 4 * $urandom_range(8), 1, 0);
      else if (r < 80) t = mk(TK_BARE, $urandom_range(7), $urandom_range(40), 0,
                              $urandom_range(3) != 0);
      else if (r < 85) t = mk(TK_QUOTED, $urandom, $urandom, $urandom, $urandom);
      else if (r < 97) begin
        t = mk(TK_BARE, $urandom, $urandom, $urandom, $urandom);
        t.triple = 1'($urandom); t.space2 = 1'($urandom);
        t.offset = 16'($urandom); t.length = 16'($urandom);
      end else t = mk(TK_FILE_END, $urandom, $urandom, 0, 1);
      send_token(t);
      if ($urandom_range(3) == 0) send_line_end();
    end
  endtask

  task automatic drain();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    token_t t;
    sb = new();
    sb.clear();
    sb.mismatches = 0;
    cycles = 0;
    rst_n = 0; in_valid = 0; tok = '0; out_stall = 0;
    send_idle = 0; recv_stall = 0; hold_off = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flags, directives, nesting, pops, errors, file end
    for (int c = 1; c <= 7; c++) begin
      t = mk(TK_BARE, c, 0, 0, 1);
      t.length = (c == 1) ? 16'd0 : 16'hffff;
      t.offset = 16'hffff;
      send_token(t);
    end
    t = mk(TK_BARE, LC_DASH, 0, 0, 1); t.triple = 1; send_token(t);
    send_line_end();
    send_token(mk(TK_BARE, LC_DASH, 0, 0, 0));
    send_token(mk(TK_BARE, LC_OTHER, 2, 1, 0));
    t = mk(TK_BARE, LC_OTHER, 3, 0, 0); t.offset = 16'hfff0; send_token(t);
    t = mk(TK_QUOTED, 0, 0, 0, 0); send_token(t);
    t = mk(TK_LINE_END, 0, 0, 0, 0); t.offset = 16'h0005; t.length = 16'hffff;
    t.eol = 1; send_token(t);
    send_token(mk(TK_BARE, LC_OTHER, 255, 0, 1));
    send_token(mk(TK_BARE, LC_OTHER, 6, 1, 1));
    send_line_end();
    send_token(mk(TK_BARE, LC_OTHER, 255, 1, 1));
    send_line_end();
    send_token(mk(TK_BARE, LC_OTHER, 1, 1, 1));
    send_line_end();
    send_token(mk(TK_BARE, 4'd15, 0, 0, 1));
    send_token(mk(TK_QUOTED, 0, 9, 0, 1));
    send_token(mk(TK_FILE_END, 0, 0, 0, 1));
    // deep nesting to overflow the stack, then a full dedent
    for (int d = 1; d <= 34; d++) begin
      send_token(mk(TK_BARE, (d % 2) ? LC_DASH : LC_OTHER, d + 10, d % 2 == 0, 1));
      send_line_end();
    end
    send_token(mk(TK_BARE, LC_DASH, 0, 0, 1));
    in_valid <= 1'b0;
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 13) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 53 : 13) : 0;
      random_tokens(100);
    end

    // receiver holds off long while tokens keep coming
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        random_tokens(40);
        in_valid <= 1'b0;
      end
    join
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/ybi_pkg.sv
design/yaml_block_indent_event_parser_top.sv
design/ybi_checker.sv
sim/tb.sv
